[rtl/core/aip_pkg.sv]
// Shared types, constants and character helpers for the base-n integer parser.
// Used by the channel interfaces, the digit decoder, the step logic and the top level.
// No dependencies.
`default_nettype none

package aip_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF = 8;
    localparam int TABLE_ENTRIES  = 80;

    localparam int BASE_BITS      = 7;
    localparam int DIGIT_BITS     = 6;
    localparam int CHAR_BITS      = 8;
    localparam int CONSUMED_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_VALUE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNED_MODE = 2'd1;

    localparam logic [BASE_BITS-1:0] BASE_RESET   = 7'd10;
    localparam logic                 SIGNED_RESET = 1'b1;

    localparam logic [BASE_BITS-1:0] BASE_OCT      = 7'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC_MAX  = 7'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX      = 7'd16;
    localparam logic [BASE_BITS-1:0] BASE_B32_MAX  = 7'd32;
    localparam logic [BASE_BITS-1:0] BASE_B64_MAX  = 7'd64;

    localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_TWO    = 8'h32;
    localparam logic [CHAR_BITS-1:0] CH_SEVEN  = 8'h37;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_F   = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_F   = 8'h66;
    localparam logic [CHAR_BITS-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [2:0] {
        PH_LEAD     = 3'd0,
        PH_SIGN_WS  = 3'd1,
        PH_HEX_ZERO = 3'd2,
        PH_HEX_BSL  = 3'd3,
        PH_DIGITS   = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NO_DIGITS = 2'd2
    } status_t;

    typedef struct packed {
        logic                  valid;
        logic [DIGIT_BITS-1:0] digit;
    } digit_t;

    // Control and status leaving the step logic for one character.
    typedef struct packed {
        phase_t  phase;
        logic    negative;
        logic    wrap;
        logic    seen;
        logic    fire;
        status_t status;
        logic    overflow;
    } step_ctl_t;

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_BS) && (c <= CH_CR));
    endfunction

    function automatic logic is_x(input logic [CHAR_BITS-1:0] c);
        return (c == CH_LO_X) || (c == CH_UP_X);
    endfunction

endpackage

`default_nettype wire

[rtl/core/aip_if.sv]
// Valid/ready channel interfaces for characters in and parse results out.
// Depends on aip_pkg.
`default_nettype none

interface aip_in_if;
    logic                           valid;
    logic                           ready;
    logic [aip_pkg::CHAR_BITS-1:0]  char_code;
    logic                           is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface aip_out_if #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [VALUE_BITS-1:0]             value;
    logic [aip_pkg::CONSUMED_BITS-1:0] consumed;
    logic [1:0]                        status;
    logic                              overflow;

    modport source (output valid, output value, output consumed, output status,
                    output overflow, input ready);
    modport sink   (input valid, input value, input consumed, input status,
                    input overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/aip_digit_decode.sv]
// Digit decoder: maps a character to its value under the decimal, hex,
// base32 or base64 alphabet that the radix selects. Depends on aip_pkg.
`default_nettype none

module aip_digit_decode (
    input  wire logic [aip_pkg::CHAR_BITS-1:0] char_code,
    input  wire logic [aip_pkg::BASE_BITS-1:0] base_value,
    output aip_pkg::digit_t                    digit
);

    logic [aip_pkg::CHAR_BITS-1:0] raw;
    logic [aip_pkg::CHAR_BITS-1:0] rel;
    logic                          hit;
    logic                          in_table;

    assign rel      = char_code - aip_pkg::CH_PLUS;
    assign in_table = (char_code >= aip_pkg::CH_PLUS)
                   && (rel < aip_pkg::CHAR_BITS'(aip_pkg::TABLE_ENTRIES));

    always_comb
    begin
        raw = '0;
        hit = 1'b0;
        if (in_table)
        begin
            priority if (base_value <= aip_pkg::BASE_DEC_MAX)
            begin
                if (char_code >= aip_pkg::CH_ZERO && char_code <= aip_pkg::CH_NINE)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_ZERO;
                end
            end
            else if (base_value <= aip_pkg::BASE_HEX)
            begin
                priority if (char_code >= aip_pkg::CH_ZERO && char_code <= aip_pkg::CH_NINE)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_ZERO;
                end
                else if (char_code >= aip_pkg::CH_UP_A && char_code <= aip_pkg::CH_UP_F)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_UP_A + 8'd10;
                end
                else if (char_code >= aip_pkg::CH_LO_A && char_code <= aip_pkg::CH_LO_F)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_LO_A + 8'd10;
                end
                else
                begin
                    hit = 1'b0;
                end
            end
            else if (base_value <= aip_pkg::BASE_B32_MAX)
            begin
                priority if (char_code >= aip_pkg::CH_UP_A && char_code <= aip_pkg::CH_UP_Z)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_UP_A;
                end
                else if (char_code >= aip_pkg::CH_TWO && char_code <= aip_pkg::CH_SEVEN)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_TWO + 8'd26;
                end
                else
                begin
                    hit = 1'b0;
                end
            end
            else if (base_value <= aip_pkg::BASE_B64_MAX)
            begin
                priority if (char_code >= aip_pkg::CH_UP_A && char_code <= aip_pkg::CH_UP_Z)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_UP_A;
                end
                else if (char_code >= aip_pkg::CH_LO_A && char_code <= aip_pkg::CH_LO_Z)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_LO_A + 8'd26;
                end
                else if (char_code >= aip_pkg::CH_ZERO && char_code <= aip_pkg::CH_NINE)
                begin
                    hit = 1'b1;
                    raw = char_code - aip_pkg::CH_ZERO + 8'd52;
                end
                else if (char_code == aip_pkg::CH_PLUS)
                begin
                    hit = 1'b1;
                    raw = 8'd62;
                end
                else if (char_code == aip_pkg::CH_SLASH)
                begin
                    hit = 1'b1;
                    raw = 8'd63;
                end
                else
                begin
                    hit = 1'b0;
                end
            end
            else
            begin
                hit = 1'b0;
            end
        end
    end

    // A digit not below the radix ends the number.
    assign digit.digit = raw[aip_pkg::DIGIT_BITS-1:0];
    assign digit.valid = hit && ({1'b0, raw[aip_pkg::DIGIT_BITS-1:0]} < base_value);

endmodule

`default_nettype wire

[rtl/core/aip_step.sv]
// Per-character step logic: phase decisions, the accumulator multiply-add,
// count update and result formatting. Depends on aip_pkg and aip_digit_decode.
`default_nettype none

module aip_step #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
    input  wire aip_pkg::phase_t                  phase,
    input  wire logic [VALUE_BITS-1:0]            acc,
    input  wire logic [COUNT_BITS-1:0]            char_count,
    input  wire logic                             negative,
    input  wire logic                             wrap,
    input  wire logic                             seen,
    input  wire logic [aip_pkg::BASE_BITS-1:0]    base_value,
    input  wire logic                             signed_mode,
    input  wire logic [aip_pkg::CHAR_BITS-1:0]    char_code,
    input  wire logic                             is_last,
    output aip_pkg::step_ctl_t                    ctl,
    output logic [VALUE_BITS-1:0]                 acc_next,
    output logic [COUNT_BITS-1:0]                 count_next,
    output logic [VALUE_BITS-1:0]                 res_value,
    output logic [aip_pkg::CONSUMED_BITS-1:0]     res_consumed
);

    localparam int PROD_BITS = VALUE_BITS + aip_pkg::BASE_BITS;
    localparam int EXT_BITS  = COUNT_BITS + aip_pkg::CONSUMED_BITS;
    localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    aip_pkg::digit_t dc;
    aip_pkg::digit_t dz;

    logic                  space_c;
    logic                  x_c;
    logic                  body;
    logic                  zero_step;
    logic                  digit_try;
    logic [VALUE_BITS-1:0] mul_op;
    logic [PROD_BITS-1:0]  prod;
    logic                  prod_wrap;
    logic [1:0]            inc;
    logic                  fin;
    logic                  empty;
    logic [VALUE_BITS-1:0] acc_s;
    logic                  wrap_s;
    logic                  seen_s;
    logic                  neg_s;
    aip_pkg::phase_t       phase_s;
    logic                  fire_c;
    aip_pkg::phase_t       phase_c;
    logic [COUNT_BITS:0]   cnt_sum;
    logic [EXT_BITS-1:0]   cnt_ext;
    logic                  ok;

    aip_digit_decode u_dec_char (
        .char_code  (char_code),
        .base_value (base_value),
        .digit      (dc)
    );

    // Value of a deferred hex '0' under the current radix.
    aip_digit_decode u_dec_zero (
        .char_code  (aip_pkg::CH_ZERO),
        .base_value (base_value),
        .digit      (dz)
    );

    assign space_c = aip_pkg::is_space(char_code);
    assign x_c     = aip_pkg::is_x(char_code);

    // A deferred hex '0' is the first digit, so the accumulator is zero there.
    assign mul_op    = zero_step ? VALUE_BITS'(dz.digit) : acc;
    assign prod      = (PROD_BITS'(mul_op) * PROD_BITS'(base_value)) + PROD_BITS'(dc.digit);
    assign prod_wrap = |prod[PROD_BITS-1:VALUE_BITS];

    // Phase decisions.
    always_comb
    begin
        phase_s   = phase;
        neg_s     = negative;
        body      = 1'b0;
        zero_step = 1'b0;
        digit_try = 1'b0;
        fin       = 1'b0;
        empty     = 1'b0;
        inc       = 2'd0;
        unique case (phase)
            aip_pkg::PH_LEAD:
            begin
                priority if (char_code == aip_pkg::CH_NUL && char_count == '0)
                begin
                    fin   = 1'b1;
                    empty = 1'b1;
                end
                else if (space_c)
                begin
                    inc = 2'd1;
                end
                else if (char_code == aip_pkg::CH_PLUS
                         || (char_code == aip_pkg::CH_MINUS && signed_mode))
                begin
                    neg_s   = (char_code == aip_pkg::CH_MINUS);
                    inc     = 2'd1;
                    phase_s = aip_pkg::PH_SIGN_WS;
                end
                else
                begin
                    body = 1'b1;
                end
            end
            aip_pkg::PH_SIGN_WS:
            begin
                if (space_c)
                    inc = 2'd1;
                else
                    body = 1'b1;
            end
            aip_pkg::PH_HEX_ZERO:
            begin
                priority if (x_c)
                begin
                    inc     = 2'd2;
                    phase_s = aip_pkg::PH_DIGITS;
                end
                else if (dz.valid)
                begin
                    zero_step = 1'b1;
                    digit_try = 1'b1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            aip_pkg::PH_HEX_BSL:
            begin
                if (x_c)
                begin
                    inc     = 2'd2;
                    phase_s = aip_pkg::PH_DIGITS;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                digit_try = 1'b1;
            end
            aip_pkg::PH_DONE:
            begin
                phase_s = aip_pkg::PH_DONE;
            end
            default:
            begin
                phase_s = phase;
            end
        endcase

        // Start of the number body: radix prefixes, then a plain digit.
        if (body)
        begin
            priority if (base_value == aip_pkg::BASE_HEX && x_c)
            begin
                inc     = 2'd1;
                phase_s = aip_pkg::PH_DIGITS;
            end
            else if (base_value == aip_pkg::BASE_HEX && char_code == aip_pkg::CH_ZERO)
            begin
                phase_s = aip_pkg::PH_HEX_ZERO;
            end
            else if (base_value == aip_pkg::BASE_HEX && char_code == aip_pkg::CH_BSLASH)
            begin
                phase_s = aip_pkg::PH_HEX_BSL;
            end
            else if (base_value == aip_pkg::BASE_OCT && char_code == aip_pkg::CH_BSLASH)
            begin
                inc     = 2'd1;
                phase_s = aip_pkg::PH_DIGITS;
            end
            else
            begin
                digit_try = 1'b1;
            end
        end
    end

    // Accumulate, and close out a string that ends early.
    always_comb
    begin
        acc_s  = acc;
        wrap_s = wrap;
        seen_s = seen;
        if (zero_step)
        begin
            acc_s  = VALUE_BITS'(dz.digit);
            seen_s = 1'b1;
        end
        if (digit_try && dc.valid)
        begin
            acc_s  = prod[VALUE_BITS-1:0];
            wrap_s = wrap | prod_wrap;
            seen_s = 1'b1;
        end
        fire_c  = fin || (digit_try && !dc.valid);
        phase_c = (digit_try && dc.valid) ? aip_pkg::PH_DIGITS : phase_s;
        cnt_sum = {1'b0, char_count} + (COUNT_BITS+1)'(inc)
                + (COUNT_BITS+1)'(zero_step) + (COUNT_BITS+1)'(digit_try && dc.valid);

        if (is_last && !fire_c && phase_c != aip_pkg::PH_DONE)
        begin
            // Pending hex '0' at the end of the string still counts as a digit.
            if (phase_c == aip_pkg::PH_HEX_ZERO && dz.valid)
            begin
                acc_s   = VALUE_BITS'(dz.digit);
                seen_s  = 1'b1;
                cnt_sum = cnt_sum + (COUNT_BITS+1)'(1);
            end
            fire_c = 1'b1;
        end
        if (fire_c)
            phase_c = aip_pkg::PH_DONE;

        count_next = (cnt_sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                           : cnt_sum[COUNT_BITS-1:0];
    end

    assign ctl.fire     = fire_c;
    assign ctl.phase    = phase_c;
    assign ctl.negative = neg_s;
    assign ctl.wrap     = wrap_s;
    assign ctl.seen     = seen_s;
    assign acc_next     = acc_s;

    // Result formatting.
    assign ok           = !empty && seen_s;
    assign ctl.status   = empty ? aip_pkg::ST_EMPTY
                        : (seen_s ? aip_pkg::ST_OK : aip_pkg::ST_NO_DIGITS);
    assign ctl.overflow = ok && wrap_s;
    assign cnt_ext      = EXT_BITS'(count_next);
    assign res_value    = !ok ? '0 : (neg_s ? ('0 - acc_s) : acc_s);
    assign res_consumed = !ok ? '0
                        : ((cnt_ext > EXT_BITS'(8'hFF)) ? 8'hFF
                                                        : cnt_ext[aip_pkg::CONSUMED_BITS-1:0]);

endmodule

`default_nettype wire

[rtl/core/ascii_integer_parser_base_n.sv]
// Top level of the streaming base-n integer parser: configuration registers,
// parse state, handshake and result register. Depends on aip_pkg, aip_if, aip_step.
//
// Usage:
//   char_in carries one character per transfer (char_code, is_last). The parser
//   skips white space, takes a sign and a radix prefix, accumulates digits and
//   gives one transfer on result_out per string (value, consumed, status,
//   overflow) when the number ends; later characters are dropped until is_last.
//   is_last always rearms the parser for the next string.
//   Throughput: one character per cycle while char_in is not stalled. The whole
//   step for a character, with the single multiply-add of the accumulator by
//   the radix, sits between the parse state registers and the result register.
//   Latency: the result is valid in the cycle after the transfer of the
//   character that ends the number.
//   Stall: while a result waits and the receiver holds ready low, char_in.ready
//   drops; it returns as soon as the result is taken, in the same cycle.
//   Configuration: cfg_we writes base_value (index 0) or signed_mode (index 1)
//   from cfg_data; write only while no string is in flight.
//   Reset: rst_n clears the parse state and the result valid and loads the
//   radix 10 and signed mode; there is no clearing pass.
`default_nettype none

module ascii_integer_parser_base_n #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [aip_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [aip_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    aip_in_if.sink                                   char_in,
    aip_out_if.source                                result_out
);

    // Configuration.
    logic [aip_pkg::BASE_BITS-1:0] base_reg;
    logic                          signed_reg;

    // Parse state.
    aip_pkg::phase_t               phase_reg;
    aip_pkg::phase_t               phase_next;
    logic [VALUE_BITS-1:0]         acc_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic                          neg_reg;
    logic                          wrap_reg;
    logic                          seen_reg;

    // Result register.
    logic                              out_valid_reg;
    logic [VALUE_BITS-1:0]             out_value_reg;
    logic [aip_pkg::CONSUMED_BITS-1:0] out_consumed_reg;
    aip_pkg::status_t                  out_status_reg;
    logic                              out_overflow_reg;

    aip_pkg::step_ctl_t                ctl;
    logic [VALUE_BITS-1:0]             acc_next;
    logic [COUNT_BITS-1:0]             count_next;
    logic [VALUE_BITS-1:0]             res_value;
    logic [aip_pkg::CONSUMED_BITS-1:0] res_consumed;
    logic                              in_xfer;

    // Take a character whenever the result register is free or being emptied.
    assign char_in.ready = !out_valid_reg || result_out.ready;
    assign in_xfer       = char_in.valid && char_in.ready;

    aip_step #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .phase        (phase_reg),
        .acc          (acc_reg),
        .char_count   (count_reg),
        .negative     (neg_reg),
        .wrap         (wrap_reg),
        .seen         (seen_reg),
        .base_value   (base_reg),
        .signed_mode  (signed_reg),
        .char_code    (char_in.char_code),
        .is_last      (char_in.is_last),
        .ctl          (ctl),
        .acc_next     (acc_next),
        .count_next   (count_next),
        .res_value    (res_value),
        .res_consumed (res_consumed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= aip_pkg::BASE_RESET;
            signed_reg <= aip_pkg::SIGNED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aip_pkg::CFG_BASE_VALUE:  base_reg   <= cfg_data[aip_pkg::BASE_BITS-1:0];
                aip_pkg::CFG_SIGNED_MODE: signed_reg <= cfg_data[0];
                default:                  base_reg   <= base_reg;
            endcase
        end
    end

    // Next phase: is_last rearms, otherwise follow the step.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_xfer)
            phase_next = char_in.is_last ? aip_pkg::PH_LEAD : ctl.phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aip_pkg::PH_LEAD;
            acc_reg   <= '0;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            wrap_reg  <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (in_xfer)
            begin
                if (char_in.is_last)
                begin
                    acc_reg   <= '0;
                    count_reg <= '0;
                    neg_reg   <= 1'b0;
                    wrap_reg  <= 1'b0;
                    seen_reg  <= 1'b0;
                end
                else
                begin
                    acc_reg   <= acc_next;
                    count_reg <= count_next;
                    neg_reg   <= ctl.negative;
                    wrap_reg  <= ctl.wrap;
                    seen_reg  <= ctl.seen;
                end
            end
        end
    end

    // Result valid: set on a finishing character, drop once the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && ctl.fire)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload needs no reset; load it with the finishing character.
    always_ff @(posedge clk)
    begin
        if (in_xfer && ctl.fire)
        begin
            out_value_reg    <= res_value;
            out_consumed_reg <= res_consumed;
            out_status_reg   <= ctl.status;
            out_overflow_reg <= ctl.overflow;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.value    = out_value_reg;
    assign result_out.consumed = out_consumed_reg;
    assign result_out.status   = out_status_reg;
    assign result_out.overflow = out_overflow_reg;

endmodule

`default_nettype wire
